>>> hw/rtl/bsoc_pkg.sv
package bsoc_pkg;

  localparam int MvW    = 16;
  localparam int PctW   = 15;
  localparam int SegW   = 4;
  localparam int DeltaW = 9;
  localparam int NumW   = 20;
  localparam int QuotW  = 12;
  localparam int RecW   = 28;
  localparam int RecSh  = 32;
  localparam int NumSeg = 10;

  localparam logic [MvW-1:0]  BottomMv = 16'd3300;
  localparam logic [MvW-1:0]  TopMv    = 16'd4200;
  localparam logic [PctW-1:0] StepQ8   = 15'd2560;
  localparam logic [PctW-1:0] FullQ8   = 15'd25600;

  // stage 1 to stage 2
  typedef struct packed {
    logic              below;
    logic              full;
    logic [SegW-1:0]   seg;
    logic [DeltaW-1:0] delta;
  } seg_t;

  // stage 2 to stage 3
  typedef struct packed {
    logic              below;
    logic              full;
    logic [SegW-1:0]   seg;
    logic [NumW-1:0]   num;
    logic [QuotW-1:0]  quot;
  } quot_t;

  // discharge curve breakpoints in millivolts, 0 to 100 percent in 10 percent steps
  function automatic logic [MvW-1:0] bp_mv(input logic [SegW-1:0] idx);
    logic [MvW-1:0] v;
    case (idx)
      4'd0:    v = 16'd3300;
      4'd1:    v = 16'd3584;
      4'd2:    v = 16'd3678;
      4'd3:    v = 16'd3725;
      4'd4:    v = 16'd3748;
      4'd5:    v = 16'd3775;
      4'd6:    v = 16'd3815;
      4'd7:    v = 16'd3873;
      4'd8:    v = 16'd3951;
      4'd9:    v = 16'd4036;
      4'd10:   v = 16'd4200;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // width of segment in millivolts, indexed by upper breakpoint
  function automatic logic [DeltaW-1:0] seg_span(input logic [SegW-1:0] seg);
    logic [DeltaW-1:0] v;
    case (seg)
      4'd1:    v = 9'd284;
      4'd2:    v = 9'd94;
      4'd3:    v = 9'd47;
      4'd4:    v = 9'd23;
      4'd5:    v = 9'd27;
      4'd6:    v = 9'd40;
      4'd7:    v = 9'd58;
      4'd8:    v = 9'd78;
      4'd9:    v = 9'd85;
      4'd10:   v = 9'd164;
      default: v = 9'd1;
    endcase
    return v;
  endfunction

  // floor(2^32 / span), so the estimate is low by at most one
  function automatic logic [RecW-1:0] seg_recip(input logic [SegW-1:0] seg);
    logic [RecW-1:0] v;
    case (seg)
      4'd1:    v = 28'd15123124;
      4'd2:    v = 28'd45691141;
      4'd3:    v = 28'd91382282;
      4'd4:    v = 28'd186737708;
      4'd5:    v = 28'd159072862;
      4'd6:    v = 28'd107374182;
      4'd7:    v = 28'd74051160;
      4'd8:    v = 28'd55063683;
      4'd9:    v = 28'd50529027;
      4'd10:   v = 28'd26188824;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/bsoc_seg.sv
module bsoc_seg
  import bsoc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [MvW-1:0] in_mv,
  output logic           out_valid,
  input  logic           out_ready,
  output seg_t           out_data
);

  seg_t seg_next;

  assign in_ready = !out_valid || out_ready;

  // find first breakpoint at or above the voltage
  always_comb begin
    logic [SegW-1:0] k_sel;
    logic [MvW-1:0]  diff;
    k_sel = SegW'(NumSeg);
    for (int k = NumSeg; k >= 1; k--) begin
      if (in_mv <= bp_mv(SegW'(k))) begin
        k_sel = SegW'(k);
      end
    end
    diff = in_mv - bp_mv(k_sel - 4'd1);
    seg_next.below = (in_mv < BottomMv);
    seg_next.full  = (in_mv > TopMv);
    seg_next.seg   = k_sel;
    seg_next.delta = (in_mv < BottomMv || in_mv > TopMv) ? '0 : diff[DeltaW-1:0];
  end

  // valid follows the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= seg_next;
    end
  end

endmodule

>>> hw/rtl/bsoc_mul.sv
module bsoc_mul
  import bsoc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  seg_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output quot_t out_data
);

  logic [NumW-1:0]        num;
  logic [NumW+RecW-1:0]   prod;
  quot_t                  quot_next;

  assign in_ready = !out_valid || out_ready;

  // scale offset by 2560 and multiply by segment reciprocal
  assign num  = (NumW'(in_data.delta) << 11) + (NumW'(in_data.delta) << 9);
  assign prod = (NumW+RecW)'(num) * (NumW+RecW)'(seg_recip(in_data.seg));

  always_comb begin
    quot_next.below = in_data.below;
    quot_next.full  = in_data.full;
    quot_next.seg   = in_data.seg;
    quot_next.num   = num;
    quot_next.quot  = prod[RecSh+QuotW-1:RecSh];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= quot_next;
    end
  end

endmodule

>>> hw/rtl/bsoc_fix.sv
module bsoc_fix
  import bsoc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  quot_t           in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PctW-1:0] out_pct
);

  logic [NumW:0]     back;
  logic [NumW:0]     rem;
  logic [QuotW-1:0]  quot;
  logic [PctW-1:0]   base;
  logic [PctW-1:0]   pct_next;

  assign in_ready = !out_valid || out_ready;

  // remainder check lifts the estimate by one when it fell short
  assign back = (NumW+1)'(in_data.quot) * (NumW+1)'(seg_span(in_data.seg));
  assign rem  = (NumW+1)'(in_data.num) - back;
  assign quot = (rem >= (NumW+1)'(seg_span(in_data.seg))) ? in_data.quot + 12'd1 : in_data.quot;

  // add segment base and saturate
  assign base = PctW'(in_data.seg - 4'd1) * StepQ8;

  always_comb begin
    if (in_data.below) begin
      pct_next = '0;
    end else if (in_data.full) begin
      pct_next = FullQ8;
    end else begin
      pct_next = base + PctW'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_pct <= pct_next;
    end
  end

endmodule

>>> hw/rtl/battery_soc_interpolator_unit.sv
// battery state of charge from voltage, piecewise linear over an 11-point
// discharge curve spaced 10 percent apart
//
// input stream: s_axis_tdata carries the voltage in whole millivolts; one
// transaction per sample. output stream: m_axis_tdata carries the state of
// charge in percent times 256, truncated and saturated to 0..25600.
//
// from accepted input to the output register a sample passes, in order, through
// segment search and offset, reciprocal multiply, then remainder correction,
// base add and saturation. one sample is taken every cycle unless the output stalls;
// the 20 x 28 bit reciprocal multiply in the middle stage sets the stage depth.
//
// each stage holds its own valid bit and is ready when empty or when the
// stage after it moves, so a stalled receiver holds the result in the output
// register while earlier stages keep filling; nothing is dropped or repeated.
// reset clears all valid bits; no results are presented until new input.
module battery_soc_interpolator_unit
  import bsoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] battery_mv
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [14:0] charge_pct_q8, [15] zero
);

  logic            v1;
  logic            r1;
  seg_t            d1;
  logic            v2;
  logic            r2;
  quot_t           d2;
  logic [PctW-1:0] pct;

  // segment search
  bsoc_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mv     (s_axis_tdata),
    .out_valid (v1),
    .out_ready (r1),
    .out_data  (d1)
  );

  // reciprocal multiply
  bsoc_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r2),
    .out_data  (d2)
  );

  // correction and saturation
  bsoc_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_data   (d2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pct   (pct)
  );

  assign m_axis_tdata = {1'b0, pct};

endmodule
